### rtl/dspe_pkg.sv
// ----------------------------------------------------------------------------
// dspe_pkg: shared definitions of the dense shortest-path engine
// Field widths, codes and the payload types of the input and result channels.
// ----------------------------------------------------------------------------
package dspe_pkg;

  localparam int unsigned NodesDefault = 16;
  localparam int unsigned NodeW        = 4;
  localparam int unsigned DistW        = 16;

  // Distance and weight value that stands for "no edge" or "unreachable".
  localparam logic [DistW-1:0] NoEdge = 16'hFFFF;

  // Operation codes of an input item.
  localparam logic OpLoad = 1'b0;
  localparam logic OpRun  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [NodeW-1:0] row;
    logic [NodeW-1:0] col;
    logic [DistW-1:0] weight;
    logic [NodeW-1:0] source_node;
  } in_item_t;

  typedef struct packed {
    logic [NodeW-1:0] node;
    logic [DistW-1:0] dist_res;
    logic             found;
    logic             last;
  } out_item_t;

endpackage

### rtl/dspe_if.sv
// ----------------------------------------------------------------------------
// dspe_in_if / dspe_out_if: valid-ready channels of the shortest-path engine
// A transfer takes place at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface dspe_in_if;
  import dspe_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dspe_out_if;
  import dspe_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/dspe_ram.sv
// ----------------------------------------------------------------------------
// dspe_ram: simple dual-port synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dspe_ram #(
  parameter int unsigned DEPTH = dspe_pkg::NodesDefault,
  parameter int unsigned WIDTH = dspe_pkg::DistW,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dense_shortest_path_engine_core.sv
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_core: Dijkstra engine on a dense weight matrix
// Usage: items arrive on in_i. A load item (op = load) writes one edge weight
// into the NODES x NODES matrix and gives no result. A run
// item (op = run) names a source node; the engine then settles the other
// nodes in order of distance (ties to the lowest index) and delivers one
// result per settled node on out_o, the final one flagged by last. A run
// ends early with one result with found = 0 once nothing reachable remains,
// and a source outside the matrix gives that result at once.
// Flow: a run first copies the source's matrix row into the distance RAM,
// then each settled node issues its result and, unless it is the last,
// starts a relaxation sweep, in which the edge RAM and the distance RAM are
// read one entry a cycle and the next minimum is found on the fly. in_i is
// ready only between runs. Results sit in an output register; while the
// receiver stalls, the engine waits at the next result until it is free.
// Reset empties the output register, clears the settled flags and returns to
// idle; the matrix holds no defined contents until every entry is loaded.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine_core #(
  parameter int unsigned NODES = dspe_pkg::NodesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  dspe_in_if.sink           in_i,
  dspe_out_if.source        out_o
);
  import dspe_pkg::*;

  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned CW = $clog2(NODES + 1);
  localparam int unsigned AW = $clog2(NODES * NODES);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StInit  = 4'b0010,
    StEmit  = 4'b0100,
    StRelax = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic [IW-1:0]    pidx_q, pidx_d;
  logic [IW-1:0]    row_q, row_d;
  logic [DistW-1:0] cur_dist_q, cur_dist_d;
  logic [DistW-1:0] rmin_q, rmin_d;
  logic [IW-1:0]    rpick_q, rpick_d;
  logic             rany_q, rany_d;
  logic [IW-1:0]    step_q, step_d;
  logic [NODES-1:0] settled_q, settled_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_data_q, out_data_d;

  logic             in_xfer;
  logic             load_ok;
  logic             src_ok;
  logic             issue;
  logic             sweep;
  logic             ew_we;
  logic [AW-1:0]    ew_waddr;
  logic [AW-1:0]    ew_raddr;
  logic [DistW-1:0] ew_rd;
  logic             bd_we;
  logic [DistW-1:0] bd_wdata;
  logic [DistW-1:0] bd_rd;
  logic [DistW:0]   sum;
  logic [DistW-1:0] sat;
  logic             upd;
  logic [DistW-1:0] val;
  logic             cand;
  logic             can_load;
  logic             is_last;

  assign in_i.ready = (state_q == StIdle);
  assign in_xfer    = in_i.valid && in_i.ready;

  assign load_ok = (8'(in_i.data.row) < 8'(NODES)) && (8'(in_i.data.col) < 8'(NODES));
  assign src_ok  = 8'(in_i.data.source_node) < 8'(NODES);

  assign ew_we    = in_xfer && (in_i.data.op == OpLoad) && load_ok;
  assign ew_waddr = AW'(in_i.data.row) * AW'(NODES) + AW'(in_i.data.col);

  assign sweep = (state_q == StInit) || (state_q == StRelax);
  assign issue = sweep && (cnt_q < CW'(NODES));

  assign ew_raddr = AW'(row_q) * AW'(NODES) + AW'(cnt_q[IW-1:0]);

  dspe_ram #(
    .DEPTH (NODES * NODES),
    .WIDTH (DistW)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ew_we),
    .waddr_i (ew_waddr),
    .wdata_i (in_i.data.weight),
    .re_i    (issue),
    .raddr_i (ew_raddr),
    .rdata_o (ew_rd)
  );

  dspe_ram #(
    .DEPTH (NODES),
    .WIDTH (DistW)
  ) u_dist_ram (
    .clk_i   (clk_i),
    .we_i    (bd_we),
    .waddr_i (pidx_q),
    .wdata_i (bd_wdata),
    .re_i    (issue),
    .raddr_i (cnt_q[IW-1:0]),
    .rdata_o (bd_rd)
  );

  // Relaxation of one entry: saturating path sum against the stored distance.
  // The entry being written and the entry being read always differ, so the
  // distance RAM needs no forwarding.
  always_comb begin
    sum = {1'b0, cur_dist_q} + {1'b0, ew_rd};
    sat = sum[DistW] ? NoEdge : sum[DistW-1:0];
    upd = 1'b0;
    val = bd_rd;
    bd_we = 1'b0;
    bd_wdata = sat;
    if (state_q == StInit) begin
      val = (pidx_q == row_q) ? '0 : ew_rd;
      bd_we = pv_q;
      bd_wdata = val;
    end else begin
      upd = !settled_q[pidx_q] && (sat < bd_rd);
      val = upd ? sat : bd_rd;
      bd_we = pv_q && upd;
    end
    cand = pv_q && !settled_q[pidx_q] && (val < rmin_q);
  end

  assign can_load = !out_valid_q || out_o.ready;
  assign is_last  = !rany_q || (step_q == IW'(NODES - 2));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    pv_d        = issue;
    pidx_d      = cnt_q[IW-1:0];
    row_d       = row_q;
    cur_dist_d  = cur_dist_q;
    rmin_d      = rmin_q;
    rpick_d     = rpick_q;
    rany_d      = rany_q;
    step_d      = step_q;
    settled_d   = settled_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;

    if (issue) begin
      cnt_d = cnt_q + CW'(1);
    end
    if (cand) begin
      rmin_d  = val;
      rpick_d = pidx_q;
      rany_d  = 1'b1;
    end

    unique case (state_q)
      StIdle: begin
        if (in_xfer && (in_i.data.op == OpRun)) begin
          rany_d = 1'b0;
          if (src_ok) begin
            settled_d = '0;
            settled_d[IW'(in_i.data.source_node)] = 1'b1;
            row_d   = IW'(in_i.data.source_node);
            cnt_d   = '0;
            rmin_d  = NoEdge;
            step_d  = '0;
            state_d = StInit;
          end else begin
            state_d = StEmit;
          end
        end
      end
      StInit, StRelax: begin
        if (pv_q && (pidx_q == IW'(NODES - 1))) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (can_load) begin
          out_valid_d         = 1'b1;
          out_data_d.node     = rany_q ? NodeW'(rpick_q) : '0;
          out_data_d.dist_res = rany_q ? rmin_q : '0;
          out_data_d.found    = rany_q;
          out_data_d.last     = is_last;
          if (rany_q) begin
            settled_d[rpick_q] = 1'b1;
            row_d      = rpick_q;
            cur_dist_d = rmin_q;
            step_d     = step_q + IW'(1);
            rmin_d     = NoEdge;
            rany_d     = 1'b0;
            cnt_d      = '0;
          end
          state_d = is_last ? StIdle : StRelax;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      rany_q      <= 1'b0;
      step_q      <= '0;
      settled_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      rany_q      <= rany_d;
      step_q      <= step_d;
      settled_q   <= settled_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    row_q      <= row_d;
    cur_dist_q <= cur_dist_d;
    rmin_q     <= rmin_d;
    rpick_q    <= rpick_d;
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

### rtl/dspe_checker.sv
// ----------------------------------------------------------------------------
// dspe_checker: port-level checks of the shortest-path engine
// Watches the channels of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module dspe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                in_op_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input dspe_pkg::out_item_t out_data_i
);
  import dspe_pkg::*;

  // A stalled result holds its place and its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or vanished");

  // A "none found" result always closes the run and carries zeros.
  a_none_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.found |->
      out_data_i.last && (out_data_i.node == '0) && (out_data_i.dist_res == '0))
    else $error("none-found result is malformed");

  // A settled node is never reported as unreachable.
  a_reachable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.found |-> out_data_i.dist_res != NoEdge)
    else $error("settled node carries the unreachable distance");

  // A load transfer leaves the engine ready for more in the following cycle.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_op_i == OpLoad) |=> in_ready_i)
    else $error("engine not ready after a load transfer");

endmodule

bind dense_shortest_path_engine_core dspe_checker u_dspe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.data.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

### dv/dense_shortest_path_engine_core_test.sv
// ----------------------------------------------------------------------------
// dense_shortest_path_engine_core_test: shortest-path engine testbench
// Loads edge weights into the engine's matrix and issues runs from chosen
// sources. Its own Dijkstra predictor queues the settle order and distances
// that each run should give. Every result transfer is checked field by field
// against the oldest queued result. Traffic goes through phases of different
// sender and receiver back-pressure.
// ----------------------------------------------------------------------------
module dense_shortest_path_engine_core_test;
  import dspe_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Nodes      = NodesDefault;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned MaxPrints  = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  dspe_in_if  in_if ();
  dspe_out_if out_if ();

  dense_shortest_path_engine_core #(
    .NODES(Nodes)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state: the weight matrix as the engine should hold it.
  logic [DistW-1:0] edge_w [Nodes][Nodes];
  out_item_t        settle_q [$];

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned error_count;
  int unsigned stall_cycles;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < MaxPrints) begin
      $display("%0t ns: mismatch in %s: got %0d, expected %0d", $realtime, what, got,
               want);
    end
    error_count++;
  endtask

  // Works out the results of one accepted item and queues them.
  task automatic predict_settle_order(input in_item_t item);
    logic [DistW-1:0] tent [Nodes];
    bit               done [Nodes];
    logic [DistW-1:0] best;
    logic [DistW:0]   sum;
    int unsigned      pick;
    bit               any;
    out_item_t        res;
    int unsigned      src;

    if (item.op == OpLoad) begin
      if (item.row < Nodes && item.col < Nodes) begin
        edge_w[item.row][item.col] = item.weight;
      end
      return;
    end
    res = '0;
    res.last = 1'b1;
    src = item.source_node;
    if (src >= Nodes) begin
      settle_q.push_back(res);
      return;
    end
    for (int unsigned i = 0; i < Nodes; i++) begin
      tent[i] = edge_w[src][i];
      done[i] = 1'b0;
    end
    done[src] = 1'b1;
    tent[src] = '0;
    for (int unsigned step = 0; step < Nodes - 1; step++) begin
      best = NoEdge;
      pick = 0;
      any  = 1'b0;
      for (int unsigned j = 0; j < Nodes; j++) begin
        if (!done[j] && tent[j] < best) begin
          best = tent[j];
          pick = j;
          any  = 1'b1;
        end
      end
      if (!any) begin
        // Nothing reachable is left: a single closing result with found low.
        res = '0;
        res.last = 1'b1;
        settle_q.push_back(res);
        return;
      end
      done[pick]   = 1'b1;
      res.node     = NodeW'(pick);
      res.dist_res = best;
      res.found    = 1'b1;
      res.last     = (step == Nodes - 2);
      settle_q.push_back(res);
      for (int unsigned j = 0; j < Nodes; j++) begin
        sum = {1'b0, tent[pick]} + {1'b0, edge_w[pick][j]};
        if (sum > {1'b0, NoEdge}) begin
          sum = {1'b0, NoEdge};
        end
        if (!done[j] && sum < {1'b0, tent[j]}) begin
          tent[j] = sum[DistW-1:0];
        end
      end
    end
  endtask

  task automatic send_item(input in_item_t item);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.data  = item;
    in_if.valid = 1'b1;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    predict_settle_order(item);
  endtask

  task automatic send_load(input int unsigned row, input int unsigned col,
                           input int unsigned weight);
    in_item_t item;

    item             = $bits(in_item_t)'($urandom);
    item.op          = OpLoad;
    item.row         = NodeW'(row);
    item.col         = NodeW'(col);
    item.weight      = DistW'(weight);
    send_item(item);
  endtask

  task automatic send_run(input int unsigned src);
    in_item_t item;

    // The load fields are don't-care here, so they carry random bits.
    item             = $bits(in_item_t)'($urandom);
    item.weight      = DistW'($urandom);
    item.op          = OpRun;
    item.source_node = NodeW'(src);
    send_item(item);
  endtask

  // Sender holds off until every queued result has been transferred.
  task automatic wait_all_settled();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (settle_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned sender, input int unsigned receiver);
    wait_all_settled();
    send_idle = sender;
    recv_idle = receiver;
  endtask

  function automatic int unsigned pick_weight();
    int unsigned roll;

    roll = $urandom_range(0, 99);
    if (roll < 25) return NoEdge;
    if (roll < 30) return 0;
    if (roll < 45) return $urandom_range(1, 15);
    if (roll < 55) return $urandom_range(65000, 65534);
    return $urandom_range(0, 65535);
  endfunction

  task automatic fill_matrix(input int unsigned no_edge_pct, input int unsigned max_w);
    for (int unsigned r = 0; r < Nodes; r++) begin
      for (int unsigned c = 0; c < Nodes; c++) begin
        if ($urandom_range(0, 99) < no_edge_pct) begin
          send_load(r, c, NoEdge);
        end else begin
          send_load(r, c, $urandom_range(0, max_w));
        end
      end
    end
  endtask

  // Every entry loaded as "no edge": each run ends at once with found low.
  task automatic test_empty_graph();
    fill_matrix(100, 0);
    send_run(0);
    send_run(Nodes - 1);
  endtask

  task automatic test_directed_paths();
    send_load(0, 1, 65534);
    send_load(1, 2, 5);      // sum with 65534 saturates, so 2 stays unreachable from 0
    send_load(0, 3, 7);
    send_load(0, 4, 7);      // equal distances: the lower index settles first
    send_load(3, 5, 0);
    send_load(4, 5, 0);
    send_load(5, 6, 1);
    send_load(5, 15, NoEdge);
    send_load(0, 7, 0);
    send_load(15, 15, 65535);
    send_run(0);
    send_run(1);
    send_run(2);
    send_load(2, 15, 0);
    send_load(15, 8, 65534);
    send_run(2);
  endtask

  // A ring through every node gives runs that settle all the others.
  task automatic test_full_runs();
    for (int unsigned n = 0; n < Nodes; n++) begin
      send_load(n, (n + 1) % Nodes, n % 3);
    end
    send_run(0);
    send_run(Nodes - 1);
    send_run($urandom_range(0, Nodes - 1));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 30) begin
        send_run($urandom_range(0, Nodes - 1));
      end else begin
        send_load($urandom_range(0, Nodes - 1), $urandom_range(0, Nodes - 1),
                  pick_weight());
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin : check_results
    out_item_t want;
    out_item_t got;

    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got = out_if.data;
      if (settle_q.size() == 0) begin
        report_mismatch("unexpected result, node", got.node, 0);
      end else begin
        want = settle_q.pop_front();
        if (got.node !== want.node) report_mismatch("node", got.node, want.node);
        if (got.dist_res !== want.dist_res) begin
          report_mismatch("dist_res", got.dist_res, want.dist_res);
        end
        if (got.found !== want.found) report_mismatch("found", got.found, want.found);
        if (got.last !== want.last) report_mismatch("last", got.last, want.last);
      end
    end
  end

  // A run with a stalled receiver can go quiet for a while, but never this long.
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1 || (in_if.valid && in_if.ready) ||
        (out_if.valid && out_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("dense_shortest_path_engine_core_test: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    send_idle    = 26;
    recv_idle    = 74;
    error_count  = 0;
    stall_cycles = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_idling(26, 74);
    test_empty_graph();
    test_directed_paths();

    set_idling(74, 26);
    test_full_runs();

    set_idling(0, 0);
    test_random_traffic(15);

    wait_all_settled();
    repeat (4 * (Nodes + 2)) @(posedge clk_i);
    if (error_count == 0) begin
      $display("dense_shortest_path_engine_core_test: done, clean");
    end else begin
      $display("dense_shortest_path_engine_core_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dspe_pkg.sv
rtl/dspe_if.sv
rtl/dspe_ram.sv
rtl/dense_shortest_path_engine_core.sv
rtl/dspe_checker.sv
dv/dense_shortest_path_engine_core_test.sv
